### design/irps_pkg.sv
// Shared types and constants for the pulse-distance IR remote sender.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package irps_pkg;

    localparam int TIMER_BITS = 16;

    localparam logic [TIMER_BITS-1:0] MARK_TICKS  = TIMER_BITS'(6);
    localparam logic [TIMER_BITS-1:0] START_TICKS = TIMER_BITS'(39);
    localparam logic [TIMER_BITS-1:0] ONE_TICKS   = TIMER_BITS'(21);
    localparam logic [TIMER_BITS-1:0] ZERO_TICKS  = TIMER_BITS'(10);
    localparam logic [TIMER_BITS-1:0] STOP_TICKS  = TIMER_BITS'(39);
    localparam logic [TIMER_BITS-1:0] FINAL_TICKS = TIMER_BITS'(15);

    // Inter-frame gaps in milliseconds
    localparam logic [7:0] SHORT_GAP_MS = 8'(16 * 4);
    localparam logic [7:0] LONG_GAP_MS  = 8'(16 * 7);
    localparam int         GAP_STEP_MS  = 16 * 2;

    localparam logic [3:0] CHECK_SEED   = 4'hf;
    localparam logic [4:0] WORD_BITS    = 5'd16;
    localparam logic [2:0] REPEAT_COUNT = 3'd5;

    // Configuration register indexes
    localparam logic CFG_REPEAT_ENABLE = 1'b0;
    localparam logic CFG_TICKS_PER_MS  = 1'b1;

    localparam logic [7:0] TICKS_PER_MS_RESET = 8'd38;

    typedef struct packed {
        logic       cmd;
        logic [3:0] nibble_one;
        logic [3:0] nibble_two;
        logic [3:0] nibble_three;
    } req_t;

    typedef struct packed {
        logic ir_on;
        logic busy_res;
        logic rejected;
    } res_t;

    typedef struct packed {
        logic       repeat_enable;
        logic [7:0] ticks_per_ms;
    } cfg_t;

endpackage

`default_nettype wire

### design/irps_if.sv
// Valid/ready channel interfaces for send requests/ticks and per-beat results.
// Depends on irps_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface irps_req_if import irps_pkg::*;;
    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface irps_res_if import irps_pkg::*;;
    logic valid;
    logic ready;
    res_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### design/irps_seq.sv
// Frame sequencer: phase, bit and timer counters advanced once per accepted beat.
// Depends on irps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irps_seq import irps_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic accept,
    input  wire req_t item,
    input  wire cfg_t cfg,
    output res_t      result
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_LEAD_MARK,
        PH_START_GAP,
        PH_BIT_MARK,
        PH_BIT_GAP,
        PH_STOP_MARK,
        PH_STOP_GAP,
        PH_FRAME_GAP,
        PH_FINAL_GAP
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [15:0]           frame_word_reg, frame_word_next;
    logic [4:0]            bits_left_reg, bits_left_next;
    logic [TIMER_BITS-1:0] tick_timer_reg, tick_timer_next;
    logic [2:0]            frames_left_reg, frames_left_next;
    logic [1:0]            gap_select_reg, gap_select_next;

    logic                  busy;
    logic [7:0]            gap_ms;
    logic [7:0]            tpm;
    logic [15:0]           gap_ticks;
    logic [4:0]            bits_dec;
    logic [2:0]            frames_dec;
    logic [3:0]            check;

    assign busy       = (phase_reg != PH_IDLE);
    assign bits_dec   = bits_left_reg - 5'd1;
    assign frames_dec = frames_left_reg - 3'd1;
    assign check      = CHECK_SEED ^ item.nibble_one ^ item.nibble_two ^ item.nibble_three;

    // Long gaps use the repeat-gap bits of the first nibble; the word is back in
    // its loaded order once the stop gap is reached.
    assign gap_ms    = gap_select_reg[1]
                       ? (LONG_GAP_MS + 8'(GAP_STEP_MS * frame_word_reg[13:12]))
                       : SHORT_GAP_MS;
    assign tpm       = (cfg.ticks_per_ms == 8'd0) ? 8'd1 : cfg.ticks_per_ms;
    assign gap_ticks = gap_ms * tpm;

    always_comb
    begin
        phase_next       = phase_reg;
        frame_word_next  = frame_word_reg;
        bits_left_next   = bits_left_reg;
        tick_timer_next  = tick_timer_reg;
        frames_left_next = frames_left_reg;
        gap_select_next  = gap_select_reg;
        result           = '0;

        if (accept)
        begin
            if (item.cmd)
            begin
                result.busy_res = 1'b1;
                if (busy)
                begin
                    result.rejected = 1'b1;
                end
                else
                begin
                    frame_word_next  = {item.nibble_one, item.nibble_two,
                                        item.nibble_three, check};
                    bits_left_next   = WORD_BITS;
                    frames_left_next = cfg.repeat_enable ? REPEAT_COUNT : 3'd1;
                    gap_select_next  = 2'd0;
                    phase_next       = PH_LEAD_MARK;
                    tick_timer_next  = MARK_TICKS;
                end
            end
            else if (busy)
            begin
                result.busy_res = 1'b1;
                result.ir_on    = (phase_reg == PH_LEAD_MARK) || (phase_reg == PH_BIT_MARK)
                                  || (phase_reg == PH_STOP_MARK);
                if (tick_timer_reg > TIMER_BITS'(1))
                begin
                    tick_timer_next = tick_timer_reg - TIMER_BITS'(1);
                end
                else
                begin
                    unique case (phase_reg)
                        PH_LEAD_MARK:
                        begin
                            phase_next      = PH_START_GAP;
                            tick_timer_next = START_TICKS;
                        end
                        PH_START_GAP:
                        begin
                            phase_next      = PH_BIT_MARK;
                            tick_timer_next = MARK_TICKS;
                        end
                        PH_BIT_MARK:
                        begin
                            phase_next      = PH_BIT_GAP;
                            tick_timer_next = frame_word_reg[15] ? ONE_TICKS : ZERO_TICKS;
                        end
                        PH_BIT_GAP:
                        begin
                            frame_word_next = {frame_word_reg[14:0], frame_word_reg[15]};
                            bits_left_next  = bits_dec;
                            phase_next      = (bits_dec != 5'd0) ? PH_BIT_MARK : PH_STOP_MARK;
                            tick_timer_next = MARK_TICKS;
                        end
                        PH_STOP_MARK:
                        begin
                            phase_next      = PH_STOP_GAP;
                            tick_timer_next = STOP_TICKS;
                        end
                        PH_STOP_GAP:
                        begin
                            frames_left_next = frames_dec;
                            if (frames_dec != 3'd0)
                            begin
                                gap_select_next = gap_select_reg + 2'd1;
                                phase_next      = PH_FRAME_GAP;
                                tick_timer_next = TIMER_BITS'(gap_ticks);
                            end
                            else
                            begin
                                phase_next      = PH_FINAL_GAP;
                                tick_timer_next = FINAL_TICKS;
                            end
                        end
                        PH_FRAME_GAP:
                        begin
                            bits_left_next  = WORD_BITS;
                            phase_next      = PH_LEAD_MARK;
                            tick_timer_next = MARK_TICKS;
                        end
                        default:
                        begin
                            phase_next      = PH_IDLE;
                            tick_timer_next = '0;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            frame_word_reg  <= '0;
            bits_left_reg   <= '0;
            tick_timer_reg  <= '0;
            frames_left_reg <= '0;
            gap_select_reg  <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            frame_word_reg  <= frame_word_next;
            bits_left_reg   <= bits_left_next;
            tick_timer_reg  <= tick_timer_next;
            frames_left_reg <= frames_left_next;
            gap_select_reg  <= gap_select_next;
        end
    end

endmodule

`default_nettype wire

### design/irps_obuf.sv
// Two-entry result queue that registers results and decouples the two channels.
// Depends on irps_pkg and irps_res_if.
`timescale 1ns / 1ps
`default_nettype none

module irps_obuf import irps_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire res_t   push_data,
    output logic        space,
    irps_res_if.source  res
);

    logic [1:0] count_reg, count_next;
    res_t       data0_reg, data0_next;
    res_t       data1_reg, data1_next;
    logic       pop;

    assign space       = (count_reg != 2'd2);
    assign res.valid   = (count_reg != 2'd0);
    assign res.payload = data0_reg;
    assign pop         = res.valid && res.ready;

    always_comb
    begin
        count_next = count_reg;
        data0_next = data0_reg;
        data1_next = data1_reg;
        if (pop)
        begin
            data0_next = data1_reg;
        end
        if (push)
        begin
            if (count_reg == 2'd0 || (count_reg == 2'd1 && pop))
            begin
                data0_next = push_data;
            end
            else
            begin
                data1_next = push_data;
            end
        end
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data0_reg <= data0_next;
        data1_reg <= data1_next;
    end

endmodule

`default_nettype wire

### design/ir_remote_pulse_distance_sender.sv
// Top level of the pulse-distance IR remote sender: config registers, sequencer
// and result queue. Depends on irps_pkg, irps_if, irps_seq and irps_obuf.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Beat contents
// --------  ---  ---------------------------------------------------------
// req       in   cmd (0 = one carrier tick, 1 = send request) + three nibbles
// res       out  ir_on, busy_res, rejected: one beat for every req beat
// cfg_*     in   write-only: index 0 repeat_enable, index 1 ticks_per_ms
//
// A new req beat may be taken every cycle while the result queue has room.
// Its result is registered and shows on res once older results have left.
// A two-entry result queue holds results while res stalls; req.ready drops
// only when both entries are full, and comes straight from a register.
// Reset leaves the sequencer idle, repeat off and ticks_per_ms at 38.
module ir_remote_pulse_distance_sender import irps_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    irps_req_if.sink        req,
    irps_res_if.source      res,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data
);

    cfg_t cfg_reg;
    logic accept;
    logic space;
    res_t step_result;

    // User must write config only while idle (unchecked); sampled when used.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.repeat_enable <= 1'b0;
            cfg_reg.ticks_per_ms  <= TICKS_PER_MS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_REPEAT_ENABLE: cfg_reg.repeat_enable <= cfg_data[0];
                CFG_TICKS_PER_MS:  cfg_reg.ticks_per_ms  <= cfg_data;
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // Take a beat whenever the result queue has room for its result.
    assign req.ready = space;
    assign accept    = req.valid && space;

    irps_seq u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (req.payload),
        .cfg    (cfg_reg),
        .result (step_result)
    );

    irps_obuf u_obuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (step_result),
        .space     (space),
        .res       (res)
    );

endmodule

`default_nettype wire
